// ----- hw/rtl/tsh_pkg.sv -----
// Shared types, codes and score-ordering functions for the top-k score heap.
`default_nettype none

package tsh_pkg;

    typedef enum logic [1:0] {
        KIND_OFFER = 2'd0,
        KIND_DRAIN = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;
    localparam logic [6:0]  KEEP_RESET   = 7'd10;

    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] score;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic        accepted;
        logic [31:0] threshold_bits;
        logic [31:0] out_position;
        logic [31:0] out_score_bits;
        logic [6:0]  entry_count;
        logic        last;
    } result_t;

    // Monotone unsigned key of a float bit pattern; -0 folds onto +0.
    function automatic logic [31:0] score_key(input logic [31:0] bits);
        logic [31:0] b;
        begin
            b = (bits == 32'h8000_0000) ? 32'h0 : bits;
            score_key = b[31] ? ~b : (b | 32'h8000_0000);
        end
    endfunction

    // True when a ranks below b: lower score, or equal score and higher position.
    function automatic logic is_worse(input entry_t a, input entry_t b);
        logic [31:0] ka;
        logic [31:0] kb;
        begin
            ka = score_key(a.score);
            kb = score_key(b.score);
            is_worse = (ka < kb) || ((ka == kb) && (a.pos > b.pos));
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tsh_heap_mem.sv -----
// Heap entry memory: one write port and one read port with registered read data.
`default_nettype none

module tsh_heap_mem
    import tsh_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read of the entry being written returns the new value.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tsh_ctrl.sv -----
// Heap sequencer: offer insertion, root replacement, in-place heapsort and drain.
`default_nettype none

module tsh_ctrl
    import tsh_pkg::*;
#(
    parameter int MAX_KEEP = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [6:0]    cfg_wdata,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_cmd,
    input  wire entry_t        in_entry,
    output logic               out_valid,
    input  wire logic          out_ready,
    output result_t            out_result,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  wire entry_t        rd_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output entry_t             wr_data
);

    localparam int LW = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_UP, S_UP_CMP, S_OFF_ROOT, S_DN, S_DN_L, S_DN_R,
        S_HS_RD, S_HS_A, S_HS_B, S_FIN, S_FIN_RD, S_RESP, S_DR_RD, S_DR_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [6:0]    keep_reg, keep_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [CW-1:0] n_reg, n_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] s_reg, s_next;
    logic [AW-1:0] oi_reg, oi_next;
    logic [LW-1:0] w_reg, w_next;
    entry_t        wv_reg, wv_next;
    entry_t        cur_reg, cur_next;
    logic          sorting_reg, sorting_next;
    logic          acc_reg, acc_next;
    logic [31:0]   thr_reg, thr_next;
    kind_t         kind_reg, kind_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic [CW-1:0] k_eff;
    logic          out_free;
    logic [LW-1:0] l_idx, r_idx, lim_ext, i_ext;
    logic [AW-1:0] p_idx;

    always_comb begin
        if (keep_reg == 7'd0) begin
            k_eff = CW'(1);
        end else if (32'(keep_reg) > 32'(MAX_KEEP)) begin
            k_eff = CW'(MAX_KEEP);
        end else begin
            k_eff = CW'(keep_reg);
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign i_ext    = LW'(i_reg);
    assign l_idx    = {1'b0, i_reg, 1'b1};
    assign r_idx    = {1'b0, i_reg, 1'b0} + LW'(2);
    assign lim_ext  = LW'(lim_reg);
    assign p_idx    = AW'((i_reg - 1'b1) >> 1);

    always_comb begin
        logic          do_dec;
        logic          do_done;
        logic [LW-1:0] dec_w;
        entry_t        dec_v;
        logic          is_last;

        state_next     = state_reg;
        keep_next      = cfg_we ? cfg_wdata : keep_reg;
        held_next      = held_reg;
        lim_next       = lim_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        s_next         = s_reg;
        oi_next        = oi_reg;
        w_next         = w_reg;
        wv_next        = wv_reg;
        cur_next       = cur_reg;
        sorting_next   = sorting_reg;
        acc_next       = acc_reg;
        thr_next       = thr_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = cur_reg;
        in_ready       = 1'b0;
        do_dec         = 1'b0;
        do_done        = 1'b0;
        dec_w          = w_reg;
        dec_v          = wv_reg;
        is_last        = ((CW'(oi_reg) + 1'b1) == n_reg);

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cur_next = in_entry;
                    acc_next = 1'b0;
                    if (in_cmd == CMD_OFFER) begin
                        if (held_reg < k_eff) begin
                            acc_next   = 1'b1;
                            i_next     = AW'(held_reg);
                            held_next  = held_reg + 1'b1;
                            state_next = S_UP;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_OFF_ROOT;
                        end
                    end else if (held_reg == '0) begin
                        kind_next  = KIND_EMPTY;
                        thr_next   = NEG_INF_BITS;
                        state_next = S_RESP;
                    end else begin
                        n_next       = held_reg;
                        sorting_next = 1'b1;
                        s_next       = AW'(held_reg - 1'b1);
                        oi_next      = '0;
                        state_next   = (held_reg == CW'(1)) ? S_DR_RD : S_HS_RD;
                    end
                end
            end
            S_UP: begin
                if (i_reg == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    state_next = S_FIN;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = p_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                if (is_worse(cur_reg, rd_data)) begin
                    wr_data    = rd_data;
                    i_next     = p_idx;
                    state_next = S_UP;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_OFF_ROOT: begin
                if (score_key(cur_reg.score) > score_key(rd_data.score)) begin
                    acc_next     = 1'b1;
                    i_next       = '0;
                    lim_next     = held_reg;
                    sorting_next = 1'b0;
                    state_next   = S_DN;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DN: begin
                if (l_idx >= lim_ext) begin
                    wr_en   = 1'b1;
                    wr_addr = i_reg;
                    do_done = 1'b1;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(l_idx);
                    state_next = S_DN_L;
                end
            end
            S_DN_L: begin
                if (is_worse(rd_data, cur_reg)) begin
                    dec_w = l_idx;
                    dec_v = rd_data;
                end else begin
                    dec_w = i_ext;
                    dec_v = cur_reg;
                end
                w_next  = dec_w;
                wv_next = dec_v;
                if (r_idx < lim_ext) begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(r_idx);
                    state_next = S_DN_R;
                end else begin
                    do_dec = 1'b1;
                end
            end
            S_DN_R: begin
                if (is_worse(rd_data, wv_reg)) begin
                    dec_w = r_idx;
                    dec_v = rd_data;
                end
                do_dec = 1'b1;
            end
            S_HS_RD: begin
                rd_en      = 1'b1;
                rd_addr    = s_reg;
                state_next = S_HS_A;
            end
            S_HS_A: begin
                cur_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_HS_B;
            end
            S_HS_B: begin
                // The old root moves to the end of the shrinking heap.
                wr_en      = 1'b1;
                wr_addr    = s_reg;
                wr_data    = rd_data;
                i_next     = '0;
                lim_next   = CW'(s_reg);
                state_next = S_DN;
            end
            S_FIN: begin
                kind_next = KIND_OFFER;
                if (held_reg >= k_eff) begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_FIN_RD;
                end else begin
                    thr_next   = NEG_INF_BITS;
                    state_next = S_RESP;
                end
            end
            S_FIN_RD: begin
                thr_next   = rd_data.score;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    out_valid_next          = 1'b1;
                    out_next.kind           = kind_reg;
                    out_next.accepted       = (kind_reg == KIND_OFFER) && acc_reg;
                    out_next.threshold_bits = thr_reg;
                    out_next.out_position   = '0;
                    out_next.out_score_bits = '0;
                    out_next.entry_count    = (kind_reg == KIND_EMPTY) ? 7'd0 : 7'(held_reg);
                    out_next.last           = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            S_DR_RD: begin
                rd_en      = 1'b1;
                rd_addr    = oi_reg;
                state_next = S_DR_EMIT;
            end
            S_DR_EMIT: begin
                if (out_free) begin
                    out_valid_next          = 1'b1;
                    out_next.kind           = KIND_DRAIN;
                    out_next.accepted       = 1'b0;
                    out_next.threshold_bits = NEG_INF_BITS;
                    out_next.out_position   = rd_data.pos;
                    out_next.out_score_bits = rd_data.score;
                    out_next.entry_count    = 7'(n_reg);
                    out_next.last           = is_last;
                    if (is_last) begin
                        held_next  = '0;
                        state_next = S_IDLE;
                    end else begin
                        oi_next    = oi_reg + 1'b1;
                        state_next = S_DR_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // One level of sift-down resolved: settle the hole or descend.
        if (do_dec) begin
            wr_en   = 1'b1;
            wr_addr = i_reg;
            if (dec_w == i_ext) begin
                wr_data = cur_reg;
                do_done = 1'b1;
            end else begin
                wr_data    = dec_v;
                i_next     = AW'(dec_w);
                state_next = S_DN;
            end
        end

        if (do_done) begin
            if (!sorting_reg) begin
                state_next = S_FIN;
            end else if (s_reg == AW'(1)) begin
                oi_next    = '0;
                state_next = S_DR_RD;
            end else begin
                s_next     = s_reg - 1'b1;
                state_next = S_HS_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            keep_reg      <= KEEP_RESET;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            sorting_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            keep_reg      <= keep_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            sorting_reg   <= sorting_next;
        end
        lim_reg  <= lim_next;
        n_reg    <= n_next;
        i_reg    <= i_next;
        s_reg    <= s_next;
        oi_reg   <= oi_next;
        w_reg    <= w_next;
        wv_reg   <= wv_next;
        cur_reg  <= cur_next;
        acc_reg  <= acc_next;
        thr_reg  <= thr_next;
        kind_reg <= kind_next;
        out_reg  <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/topk_score_heap.sv -----
// Top-k score heap: keeps the best k (position, score) pairs and drains them sorted.
// Offer: each sift-down level reads both children through the single read port. Drain
// of n entries: an in-place heapsort, then one drained beat per entry. One item is in
// work at a time.
// Reset clears the held count and control state and sets k to 10; the entry memory
// is not cleared, since only written entries are ever read.
`default_nettype none

module topk_score_heap
    import tsh_pkg::*;
#(
    parameter int MAX_KEEP = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [6:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // position, score_bits
    input  wire logic         s_tuser,   // cmd
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // accepted, threshold_bits, out_position,
                                         // out_score_bits, entry_count
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast
);

    localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1);

    entry_t        in_entry;
    result_t       res;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    entry_t        rd_data, wr_data;

    assign in_entry.pos   = s_tdata[31:0];
    assign in_entry.score = s_tdata[63:32];

    tsh_ctrl #(
        .MAX_KEEP (MAX_KEEP),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_entry   (in_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    tsh_heap_mem #(
        .DEPTH (MAX_KEEP),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign m_tdata = {res.entry_count, res.out_score_bits, res.out_position,
                      res.threshold_bits, res.accepted};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    // The sequencer never takes a second beat right behind the first.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous item still in work");

    a_offer_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_OFFER || m_tuser == KIND_EMPTY) |-> m_tlast)
        else $error("offer or empty-drain result without last");

    a_drain_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_OFFER |-> !m_tdata[0])
        else $error("drain result marked accepted");

    a_drain_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DRAIN |-> m_tdata[103:97] != 7'd0)
        else $error("drained entry with zero count");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the top-k score heap: directed table, then random offers and drains.
`timescale 1ns / 1ps

module testbench;
    import tsh_pkg::*;

    localparam int HEAP_DEPTH = 64;

    typedef struct packed {
        logic        cmd;
        logic [31:0] pos;
        logic [31:0] score;
        logic        has_gold;
        result_t     gold;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [6:0]   cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;     // position, score_bits
    logic         s_tuser = 1'b0;   // cmd
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;          // accepted, threshold, out_position, out_score, entry_count
    logic [1:0]   m_tuser;          // kind
    logic         m_tlast;

    topk_score_heap u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Predictor state.
    entry_t      heap_mem [HEAP_DEPTH];
    int unsigned heap_held;
    logic [6:0]  keep_reg;
    result_t     pending_results [$];
    int          error_count = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] order_key(input logic [31:0] bits);
        logic [31:0] b;
        b = (bits == 32'h8000_0000) ? 32'h0 : bits;
        return b[31] ? ~b : (b | 32'h8000_0000);
    endfunction

    function automatic logic ranks_below(input entry_t a, input entry_t b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = order_key(a.score);
        kb = order_key(b.score);
        return (ka < kb) || ((ka == kb) && (a.pos > b.pos));
    endfunction

    function automatic void heap_sink(input int unsigned n, input int unsigned start);
        int unsigned i;
        int unsigned l;
        int unsigned w;
        entry_t t;
        i = start;
        forever begin
            l = 2 * i + 1;
            w = i;
            if (l < n && ranks_below(heap_mem[l], heap_mem[w])) w = l;
            if (l + 1 < n && ranks_below(heap_mem[l + 1], heap_mem[w])) w = l + 1;
            if (w == i) break;
            t = heap_mem[i]; heap_mem[i] = heap_mem[w]; heap_mem[w] = t;
            i = w;
        end
    endfunction

    function automatic int unsigned clamp_keep();
        if (keep_reg == 0) return 1;
        if (keep_reg > HEAP_DEPTH) return HEAP_DEPTH;
        return keep_reg;
    endfunction

    // Computes the results caused by one item and queues them.
    function automatic void predict_heap(input logic cmd, input logic [31:0] pos,
                                         input logic [31:0] score);
        int unsigned k;
        int unsigned i;
        int unsigned p;
        int unsigned n;
        logic full;
        logic acc;
        entry_t e;
        entry_t t;
        result_t r;
        r = '0;
        r.threshold_bits = NEG_INF_BITS;
        r.last = 1'b1;
        if (cmd == CMD_OFFER) begin
            k = clamp_keep();
            full = heap_held >= k;
            acc = !full || (order_key(score) > order_key(heap_mem[0].score));
            e.pos = pos;
            e.score = score;
            if (acc && !full) begin
                i = heap_held;
                heap_held++;
                heap_mem[i] = e;
                while (i > 0) begin
                    p = (i - 1) / 2;
                    if (!ranks_below(heap_mem[i], heap_mem[p])) break;
                    t = heap_mem[i]; heap_mem[i] = heap_mem[p]; heap_mem[p] = t;
                    i = p;
                end
            end else if (acc) begin
                heap_mem[0] = e;
                heap_sink(heap_held, 0);
            end
            r.kind = KIND_OFFER;
            r.accepted = acc;
            if (heap_held >= k) r.threshold_bits = heap_mem[0].score;
            r.entry_count = heap_held[6:0];
            pending_results.push_back(r);
        end else if (heap_held == 0) begin
            r.kind = KIND_EMPTY;
            pending_results.push_back(r);
        end else begin
            n = heap_held;
            for (i = n - 1; i > 0; i--) begin
                t = heap_mem[0]; heap_mem[0] = heap_mem[i]; heap_mem[i] = t;
                heap_sink(i, 0);
            end
            for (i = 0; i < n; i++) begin
                r.kind = KIND_DRAIN;
                r.out_position = heap_mem[i].pos;
                r.out_score_bits = heap_mem[i].score;
                r.entry_count = n[6:0];
                r.last = (i == n - 1);
                pending_results.push_back(r);
            end
            heap_held = 0;
        end
    endfunction

    // Receiver side: random stalls plus an optional long hold-off.
    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            m_tready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = kind_t'(m_tuser);
            {got.entry_count, got.out_score_bits, got.out_position, got.threshold_bits,
             got.accepted} = m_tdata;
            got.last = m_tlast;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: kind %0d", m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    error_count++;
                end
                if (got.accepted != want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                    error_count++;
                end
                if (got.threshold_bits != want.threshold_bits) begin
                    $error("threshold_bits: expected %h, got %h",
                           want.threshold_bits, got.threshold_bits);
                    error_count++;
                end
                if (got.out_position != want.out_position) begin
                    $error("out_position: expected %h, got %h",
                           want.out_position, got.out_position);
                    error_count++;
                end
                if (got.out_score_bits != want.out_score_bits) begin
                    $error("out_score_bits: expected %h, got %h",
                           want.out_score_bits, got.out_score_bits);
                    error_count++;
                end
                if (got.entry_count != want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, got.entry_count);
                    error_count++;
                end
                if (got.last != want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Offers one beat and waits for its acceptance; the predictor runs at the accept edge.
    task automatic send_beat(input logic cmd, input logic [31:0] pos, input logic [31:0] score);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {score, pos};
        do @(posedge aclk); while (!s_tready);
        predict_heap(cmd, pos, score);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_keep(input logic [6:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        keep_reg = value;
    endtask

    function automatic logic [31:0] random_score();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return 32'h7FC0_0001;
            5: return 32'hFFC0_0000;
            6: return {1'($urandom_range(1)), 8'h7F, 19'h0, 4'($urandom_range(15))};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 8)
                send_beat(CMD_DRAIN, $urandom, $urandom);
            else
                send_beat(CMD_OFFER, ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom,
                          random_score());
        end
        send_beat(CMD_DRAIN, 32'h0, 32'h0);
    endtask

    stim_row_t directed_rows [$];

    function automatic stim_row_t mk_row(input logic cmd, input logic [31:0] pos,
                                         input logic [31:0] score, input logic has_gold,
                                         input result_t gold);
        stim_row_t row;
        row.cmd = cmd; row.pos = pos; row.score = score;
        row.has_gold = has_gold; row.gold = gold;
        return row;
    endfunction

    initial begin
        result_t empty_gold;
        result_t first_offer;
        stim_row_t row;
        logic [31:0] dir_scores [12];
        heap_held = 0;
        keep_reg = KEEP_RESET;
        empty_gold = '{KIND_EMPTY, 1'b0, NEG_INF_BITS, 32'h0, 32'h0, 7'd0, 1'b1};
        first_offer = '{KIND_OFFER, 1'b1, NEG_INF_BITS, 32'h0, 32'h0, 7'd1, 1'b1};
        dir_scores = '{32'h8000_0000, 32'h0000_0000, 32'h7F80_0000, 32'hFF80_0000,
                       32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000, 32'hBF80_0000,
                       32'h3F80_0000, 32'h0000_0001, 32'h8000_0001, 32'h4000_0000};

        // Drain after reset, offers of every special score, then ties and drains.
        directed_rows.push_back(mk_row(CMD_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                       empty_gold));
        directed_rows.push_back(mk_row(CMD_OFFER, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                                       first_offer));
        foreach (dir_scores[i])
            directed_rows.push_back(mk_row(CMD_OFFER, i, dir_scores[i], 1'b0, first_offer));
        directed_rows.push_back(mk_row(CMD_OFFER, 32'h0, 32'h8000_0000, 1'b0, first_offer));
        directed_rows.push_back(mk_row(CMD_DRAIN, 32'h0, 32'h0, 1'b0, first_offer));
        directed_rows.push_back(mk_row(CMD_DRAIN, 32'h0, 32'h0, 1'b1, empty_gold));

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 30;
        recv_idle_pct = 62;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_beat(row.cmd, row.pos, row.score);
            // Typed-in rows double-check the predictor itself.
            if (row.has_gold && pending_results[$] != row.gold) begin
                $error("directed row %0d: predictor disagrees with table", i);
                error_count++;
            end
        end

        write_keep(7'd1);
        random_phase(15);
        write_keep(7'd64);
        random_phase(20);

        // Fill the heap, then lower k below the held count.
        send_idle_pct = 62;
        recv_idle_pct = 30;
        write_keep(7'd20);
        for (int i = 0; i < 20; i++) send_beat(CMD_OFFER, $urandom, random_score());
        write_keep(7'd5);
        random_phase(15);
        write_keep(7'd0);
        random_phase(10);
        write_keep(7'd127);

        // Long receiver hold-off while offers keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 300;
        random_phase(15);
        wait_drained();
        write_keep(7'd3);
        random_phase(10);

        wait_drained();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/tsh_pkg.sv
hw/rtl/tsh_heap_mem.sv
hw/rtl/tsh_ctrl.sv
hw/rtl/topk_score_heap.sv
verif/testbench.sv
